FILE: sv/led_module_frame_formatter_assert.svh
// ----------------------------------------------------------------------------
// LED module frame formatter assertion macros
// Concurrent assertion helpers on clk with the active-low reset as disable.
// ----------------------------------------------------------------------------
`ifndef LED_MODULE_FRAME_FORMATTER_ASSERT_SVH
`define LED_MODULE_FRAME_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define LMFF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lmff: property violated");
// A condition that must never be true outside reset.
`define LMFF_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lmff: forbidden condition seen");
`else
`define LMFF_ASSERT(label, prop)
`define LMFF_ASSERT_NEVER(label, expr)
`endif
`endif

FILE: sv/lmff_pkg.sv
// ----------------------------------------------------------------------------
// LED module frame formatter package
// Field widths, command codes, fixed mark positions and shared types.
// ----------------------------------------------------------------------------
package lmff_pkg;

    // Default frame geometry.
    localparam int FRAME_BYTES_DEF = 27;
    localparam int MARK_BYTES_DEF  = 17;
    localparam int ROW_DIGITS_DEF  = 5;

    // Field widths.
    localparam int FUNC_W      = 3;
    localparam int MARK_W      = 5;
    localparam int COLOR_W     = 8;
    localparam int VALUE_W     = 17;
    localparam int POS_OUT_W   = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int DIGIT_W     = 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_W);

    // Fixed mark positions.
    localparam int POS_COLON    = 1;
    localparam int POS_UP_DOT   = 2;
    localparam int POS_DOWN_DOT = 3;

    // Offset added to the blank color for an unlit digit.
    localparam logic [COLOR_W-1:0] DIGIT_OFFSET = 8'd8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_COLOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILL_ZERO   = 2'd1;

    // Command codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_MARK   = 3'd0,
        FUNC_UPPER  = 3'd1,
        FUNC_LOWER  = 3'd2,
        FUNC_CLEAR  = 3'd3,
        FUNC_UPDATE = 3'd4
    } func_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CONVERT = 5'b00010,
        ST_DIGITS  = 5'b00100,
        ST_CLEAR   = 5'b01000,
        ST_SEND    = 5'b10000
    } state_t;

    // Control from the sequencer to the decimal converter.
    typedef struct packed {
        logic load;
        logic next_digit;
    } bcd_ctl_t;

endpackage

FILE: sv/lmff_bcd.sv
// ----------------------------------------------------------------------------
// LED module frame formatter decimal converter
// Bit-serial binary to BCD conversion (shift and add three), one input bit per
// cycle, then hands the digits out most significant first, one per request.
// ----------------------------------------------------------------------------
module lmff_bcd #(
    parameter int ROW_DIGITS = lmff_pkg::ROW_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lmff_pkg::bcd_ctl_t            ctl,
    input  logic [lmff_pkg::VALUE_W-1:0]  value,
    output logic                          busy,
    output logic [lmff_pkg::DIGIT_W-1:0]  top_digit
);

    localparam int BCD_W = lmff_pkg::DIGIT_W * ROW_DIGITS;

    logic [lmff_pkg::VALUE_W-1:0]   bits_reg, bits_next;
    logic [BCD_W-1:0]               bcd_reg, bcd_next;
    logic [BCD_W-1:0]               bcd_adj;
    logic [lmff_pkg::BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;

    // Add three to every digit of five or more before the doubling shift.
    always_comb
    begin
        for (int d = 0; d < ROW_DIGITS; d++)
        begin
            if (bcd_reg[d*lmff_pkg::DIGIT_W +: lmff_pkg::DIGIT_W] >= 4'd5)
            begin
                bcd_adj[d*lmff_pkg::DIGIT_W +: lmff_pkg::DIGIT_W] =
                    bcd_reg[d*lmff_pkg::DIGIT_W +: lmff_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[d*lmff_pkg::DIGIT_W +: lmff_pkg::DIGIT_W] =
                    bcd_reg[d*lmff_pkg::DIGIT_W +: lmff_pkg::DIGIT_W];
            end
        end
    end

    // Load, convert one bit per cycle, or shift out one digit. Carries out of
    // the top digit are dropped, which keeps the low decimal digits only.
    always_comb
    begin
        bits_next = bits_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        priority if (ctl.load)
        begin
            bits_next = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next  = {bcd_adj[BCD_W-2:0], bits_reg[lmff_pkg::VALUE_W-1]};
            bits_next = {bits_reg[lmff_pkg::VALUE_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == lmff_pkg::BIT_CNT_W'(lmff_pkg::VALUE_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
        else if (ctl.next_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-lmff_pkg::DIGIT_W-1:0], {lmff_pkg::DIGIT_W{1'b0}}};
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Data shift registers.
    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        bcd_reg  <= bcd_next;
    end

    assign busy      = busy_reg;
    assign top_digit = bcd_reg[BCD_W-1 -: lmff_pkg::DIGIT_W];

endmodule

FILE: sv/led_module_frame_formatter.sv
// A mark write goes straight into the frame store; a number write shifts each value bit through
// the serial decimal converter, hands off, then writes one digit byte each.
// A clear writes every frame byte and an update sends FRAME_BYTES transfers, one byte per
// cycle while the output is taken; both are paced by one frame store access per cycle.
// Items are handled one at a time; the input is ready again once the sequencer is back in idle.
// Reset is asynchronous: marks read 0, digit bytes 8, blank_color and fill_zero are 0.
// ----------------------------------------------------------------------------
// LED module frame formatter
// Keeps the segment module frame, applies mark, number and clear commands,
// and streams the frame out byte by byte on an update command.
// ----------------------------------------------------------------------------
`include "led_module_frame_formatter_assert.svh"

module led_module_frame_formatter #(
    parameter int FRAME_BYTES = lmff_pkg::FRAME_BYTES_DEF,
    parameter int MARK_BYTES  = lmff_pkg::MARK_BYTES_DEF,
    parameter int ROW_DIGITS  = lmff_pkg::ROW_DIGITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lmff_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lmff_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input item channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lmff_pkg::FUNC_W-1:0]       func,
    input  logic [lmff_pkg::MARK_W-1:0]       mark_index,
    input  logic [lmff_pkg::COLOR_W-1:0]      color,
    input  logic [lmff_pkg::VALUE_W-1:0]      value,
    input  logic                              dot_on,
    input  logic                              colon_on,
    // Result channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lmff_pkg::COLOR_W-1:0]      frame_byte,
    output logic [lmff_pkg::POS_OUT_W-1:0]    byte_position,
    output logic                              frame_end
);

    localparam int POS_MAX_A = MARK_BYTES + 2 * ROW_DIGITS;
    localparam int POS_MAX   = (POS_MAX_A > FRAME_BYTES) ? POS_MAX_A : FRAME_BYTES;
    localparam int POS_W_RAW = $clog2(POS_MAX + 1);
    localparam int POS_W     = (POS_W_RAW > lmff_pkg::MARK_W) ? POS_W_RAW : lmff_pkg::MARK_W;
    localparam int ADDR_W    = $clog2(FRAME_BYTES);
    localparam int DIG_W     = $clog2(ROW_DIGITS + 1);

    localparam logic [POS_W-1:0] UPPER_BASE = POS_W'(MARK_BYTES);
    localparam logic [POS_W-1:0] LOWER_BASE = POS_W'(MARK_BYTES + ROW_DIGITS);
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_BYTES - 1);

    localparam logic [lmff_pkg::POS_OUT_W-1:0] LAST_OUT_POS =
        lmff_pkg::POS_OUT_W'(FRAME_BYTES - 1);

    lmff_pkg::state_t state_reg, state_next;

    logic [lmff_pkg::COLOR_W-1:0] frame_reg [FRAME_BYTES];

    logic [lmff_pkg::COLOR_W-1:0] blank_color_reg, blank_color_next;
    logic                         fill_zero_reg, fill_zero_next;

    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [DIG_W-1:0]             dig_cnt_reg, dig_cnt_next;
    logic                         leading_reg, leading_next;
    logic                         dot_pend_reg, dot_pend_next;
    logic [lmff_pkg::COLOR_W-1:0] up_dot_reg, up_dot_next;
    logic [lmff_pkg::COLOR_W-1:0] color_reg, color_next;

    logic                           out_valid_reg, out_valid_next;
    logic [lmff_pkg::COLOR_W-1:0]   out_byte_reg, out_byte_next;
    logic [lmff_pkg::POS_OUT_W-1:0] out_pos_reg, out_pos_next;
    logic                           out_end_reg, out_end_next;

    logic                         wr_en;
    logic [POS_W-1:0]             wr_pos;
    logic [lmff_pkg::COLOR_W-1:0] wr_data;

    logic                         in_fire;
    logic                         out_load;
    logic                         send_last;
    logic                         digit_last;
    logic                         digit_blank;
    logic [lmff_pkg::COLOR_W-1:0] blank_digit;
    logic [lmff_pkg::COLOR_W-1:0] dot_color;
    logic [lmff_pkg::COLOR_W-1:0] colon_color;

    lmff_pkg::bcd_ctl_t           bcd_ctl;
    logic                         conv_busy;
    logic [lmff_pkg::DIGIT_W-1:0] top_digit;

    // Serial decimal converter.
    lmff_bcd #(
        .ROW_DIGITS (ROW_DIGITS)
    ) u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (bcd_ctl),
        .value     (value),
        .busy      (conv_busy),
        .top_digit (top_digit)
    );

    // Handshakes and shared terms.
    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == lmff_pkg::ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_load    = (state_reg == lmff_pkg::ST_SEND) && (!out_valid_reg || out_ready);
    assign send_last   = (pos_reg == LAST_POS);
    assign digit_last  = (dig_cnt_reg == DIG_W'(ROW_DIGITS - 1));
    assign digit_blank = leading_reg && !digit_last && (top_digit == '0);
    assign blank_digit = blank_color_reg + lmff_pkg::DIGIT_OFFSET;
    assign dot_color   = dot_on ? color : blank_color_reg;
    assign colon_color = colon_on ? color : blank_color_reg;

    assign bcd_ctl.load = in_fire && ((lmff_pkg::func_t'(func) == lmff_pkg::FUNC_UPPER) ||
                                      (lmff_pkg::func_t'(func) == lmff_pkg::FUNC_LOWER));
    assign bcd_ctl.next_digit = (state_reg == lmff_pkg::ST_DIGITS);

    // Configuration registers.
    always_comb
    begin
        blank_color_next = blank_color_reg;
        fill_zero_next   = fill_zero_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == lmff_pkg::CFG_BLANK_COLOR)
            begin
                blank_color_next = cfg_data;
            end
            else if (cfg_index == lmff_pkg::CFG_FILL_ZERO)
            begin
                fill_zero_next = cfg_data[0];
            end
        end
    end

    // Sequencer and frame store write port.
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        dig_cnt_next  = dig_cnt_reg;
        leading_next  = leading_reg;
        dot_pend_next = dot_pend_reg;
        up_dot_next   = up_dot_reg;
        color_next    = color_reg;
        wr_en         = 1'b0;
        wr_pos        = pos_reg;
        wr_data       = blank_digit;
        unique case (state_reg)
            lmff_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    color_next = color;
                    unique case (lmff_pkg::func_t'(func))
                        lmff_pkg::FUNC_MARK:
                        begin
                            wr_en   = ({1'b0, mark_index} < (lmff_pkg::MARK_W + 1)'(MARK_BYTES));
                            wr_pos  = POS_W'(mark_index);
                            wr_data = color;
                        end
                        lmff_pkg::FUNC_UPPER:
                        begin
                            wr_en         = 1'b1;
                            wr_pos        = POS_W'(lmff_pkg::POS_COLON);
                            wr_data       = colon_color;
                            dot_pend_next = 1'b1;
                            up_dot_next   = dot_color;
                            pos_next      = UPPER_BASE;
                            state_next    = lmff_pkg::ST_CONVERT;
                        end
                        lmff_pkg::FUNC_LOWER:
                        begin
                            wr_en         = 1'b1;
                            wr_pos        = POS_W'(lmff_pkg::POS_DOWN_DOT);
                            wr_data       = dot_color;
                            dot_pend_next = 1'b0;
                            pos_next      = LOWER_BASE;
                            state_next    = lmff_pkg::ST_CONVERT;
                        end
                        lmff_pkg::FUNC_CLEAR:
                        begin
                            pos_next   = '0;
                            state_next = lmff_pkg::ST_CLEAR;
                        end
                        lmff_pkg::FUNC_UPDATE:
                        begin
                            pos_next   = '0;
                            state_next = lmff_pkg::ST_SEND;
                        end
                        default:
                        begin
                            state_next = lmff_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lmff_pkg::ST_CONVERT:
            begin
                // The upper dot goes in while the converter runs.
                if (dot_pend_reg)
                begin
                    wr_en         = 1'b1;
                    wr_pos        = POS_W'(lmff_pkg::POS_UP_DOT);
                    wr_data       = up_dot_reg;
                    dot_pend_next = 1'b0;
                end
                else if (!conv_busy)
                begin
                    dig_cnt_next = '0;
                    leading_next = !fill_zero_reg;
                    state_next   = lmff_pkg::ST_DIGITS;
                end
            end
            lmff_pkg::ST_DIGITS:
            begin
                // One digit byte per cycle, most significant first.
                wr_en        = (pos_reg < POS_W'(FRAME_BYTES));
                wr_pos       = pos_reg;
                wr_data      = digit_blank ? blank_digit
                                           : (lmff_pkg::COLOR_W'(top_digit) + color_reg);
                leading_next = digit_blank;
                pos_next     = pos_reg + 1'b1;
                dig_cnt_next = dig_cnt_reg + 1'b1;
                if (digit_last)
                begin
                    state_next = lmff_pkg::ST_IDLE;
                end
            end
            lmff_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_pos   = pos_reg;
                wr_data  = (pos_reg < POS_W'(MARK_BYTES)) ? blank_color_reg : blank_digit;
                pos_next = pos_reg + 1'b1;
                if (send_last)
                begin
                    state_next = lmff_pkg::ST_IDLE;
                end
            end
            lmff_pkg::ST_SEND:
            begin
                if (out_load)
                begin
                    pos_next = pos_reg + 1'b1;
                    if (send_last)
                    begin
                        state_next = lmff_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lmff_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: during a send, loads a frame byte whenever it is empty or being taken.
    always_comb
    begin
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = frame_reg[pos_reg[ADDR_W-1:0]];
            out_pos_next   = lmff_pkg::POS_OUT_W'(pos_reg);
            out_end_next   = send_last;
        end
    end

    // Control and configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lmff_pkg::ST_IDLE;
            blank_color_reg <= '0;
            fill_zero_reg   <= 1'b0;
            pos_reg         <= '0;
            dig_cnt_reg     <= '0;
            leading_reg     <= 1'b0;
            dot_pend_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            blank_color_reg <= blank_color_next;
            fill_zero_reg   <= fill_zero_next;
            pos_reg         <= pos_next;
            dig_cnt_reg     <= dig_cnt_next;
            leading_reg     <= leading_next;
            dot_pend_reg    <= dot_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        up_dot_reg   <= up_dot_next;
        color_reg    <= color_next;
        out_byte_reg <= out_byte_next;
        out_pos_reg  <= out_pos_next;
        out_end_reg  <= out_end_next;
    end

    // Frame store: one write per cycle, reset to blank marks and digit eights.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                frame_reg[i] <= (i < MARK_BYTES) ? '0 : lmff_pkg::DIGIT_OFFSET;
            end
        end
        else
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                if (wr_en && (wr_pos == POS_W'(i)))
                begin
                    frame_reg[i] <= wr_data;
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_byte    = out_byte_reg;
    assign byte_position = out_pos_reg;
    assign frame_end     = out_end_reg;

    // A stalled transfer holds the send pointer.
    `LMFF_ASSERT(a_send_hold, (state_reg == lmff_pkg::ST_SEND) && !out_load |=> $stable(pos_reg))
    // The end flag only marks the last frame position.
    `LMFF_ASSERT(a_end_pos, out_valid && frame_end |-> byte_position == LAST_OUT_POS)
    // No new item while the converter is still running.
    `LMFF_ASSERT_NEVER(a_busy_ready, conv_busy && in_ready)

endmodule
